### hw/rtl/glr_pkg.sv
// Shared types, constants and sizes for the glyph cell renderer.
// Used by the front end, the back end, the result queue and the top level.
// Depends on nothing else.
package glr_pkg;

    // Sizing of the cell queue and of the font store.
    localparam int QUEUE_DEPTH = 64;
    localparam int FONT_GLYPHS = 96;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int FONT_BYTES  = FONT_GLYPHS * 16;
    // Font addresses are 11 bits wide, so no byte above 2047 can be reached.
    localparam int FONT_DEPTH  = (FONT_BYTES < 2048) ? FONT_BYTES : 2048;
    localparam int FAW         = $clog2(FONT_DEPTH);

    // Limits used for range checks on font writes and glyph lookups.
    localparam logic [11:0] FONT_LIMIT  = 12'(FONT_BYTES);
    localparam logic [8:0]  GLYPH_LIMIT = 9'(FONT_GLYPHS);
    localparam logic [6:0]  GLYPH_BASE  = 7'd32;

    // Sequencer slots.
    localparam logic [8:0] SLOT_POP        = 9'd267;
    localparam logic [8:0] SLOT_WINDOW_END = 9'd11;

    // Display command bytes.
    localparam logic [7:0] CMD_COL_SET   = 8'h2a;
    localparam logic [7:0] CMD_ROW_SET   = 8'h2b;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2c;
    localparam logic [7:0] COL_SPAN      = 8'h07;
    localparam logic [7:0] ROW_SPAN      = 8'h0f;

    // Input action codes.
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_ENQUEUE = 2'd1;
    localparam logic [1:0] ACT_FONT    = 2'd2;

    // Result queue sizing.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_LW    = $clog2(OUT_DEPTH + 1);

    // One input word.
    typedef struct packed {
        logic [1:0]  action;
        logic [6:0]  char_code;
        logic [3:0]  cell_col;
        logic [3:0]  cell_row;
        logic [15:0] fg_color;
        logic [15:0] back_color;
        logic [10:0] font_addr;
        logic [7:0]  font_byte;
    } request_t;

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       dc_level;
        logic       enqueue_dropped;
    } response_t;

    // One queued character cell.
    typedef struct packed {
        logic [6:0]  glyph;
        logic [3:0]  col;
        logic [3:0]  row;
        logic [15:0] fg;
        logic [15:0] bg;
    } cell_t;

    // Classified operation passed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_TICK,
        OP_ENQUEUE,
        OP_FONT
    } op_kind_t;

    typedef struct packed {
        op_kind_t         kind;
        cell_t            cell_data;
        logic [FAW-1:0]   font_idx;
        logic [7:0]       font_byte;
    } op_t;

endpackage

### hw/rtl/glr_front.sv
// Front end of the glyph cell renderer: accepts input words, drops the ones
// that do nothing and holds the rest in a two-entry operation queue.
// Depends on glr_pkg.
module glr_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  glr_pkg::request_t  request,
    output logic               op_valid,
    output glr_pkg::op_t       op,
    input  logic               op_take
);

    glr_pkg::op_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    glr_pkg::op_t classified;
    logic         keep;
    logic         do_push;

    // Classify the incoming word; unused codes and out-of-range font writes vanish.
    always_comb
    begin
        classified.kind      = glr_pkg::OP_TICK;
        classified.cell_data = '{glyph: request.char_code, col: request.cell_col,
                                 row: request.cell_row, fg: request.fg_color,
                                 bg: request.back_color};
        classified.font_idx  = request.font_addr[glr_pkg::FAW-1:0];
        classified.font_byte = request.font_byte;
        keep                 = 1'b0;
        unique case (request.action)
            glr_pkg::ACT_TICK:
            begin
                classified.kind = glr_pkg::OP_TICK;
                keep            = 1'b1;
            end
            glr_pkg::ACT_ENQUEUE:
            begin
                classified.kind = glr_pkg::OP_ENQUEUE;
                keep            = 1'b1;
            end
            glr_pkg::ACT_FONT:
            begin
                classified.kind = glr_pkg::OP_FONT;
                keep            = ({1'b0, request.font_addr} < glr_pkg::FONT_LIMIT);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Queue control.
    assign full     = (count_reg == 2'd2);
    assign do_push  = push && !full && keep;
    assign op_valid = (count_reg != 2'd0);
    assign op       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = op_take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, op_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

### hw/rtl/glr_out_fifo.sv
// Result queue of the glyph cell renderer: holds finished result words
// until the consumer pops them. The producer never overfills it.
// Depends on glr_pkg.
module glr_out_fifo
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  glr_pkg::response_t            push_item,
    input  logic                          pop,
    output logic                          empty,
    output glr_pkg::response_t            head_item,
    output logic [glr_pkg::OUT_LW-1:0]    level
);

    glr_pkg::response_t               mem_reg [glr_pkg::OUT_DEPTH];
    logic [glr_pkg::OUT_AW-1:0]       wr_ptr_reg;
    logic [glr_pkg::OUT_AW-1:0]       rd_ptr_reg;
    logic [glr_pkg::OUT_LW-1:0]       level_reg;
    logic [glr_pkg::OUT_LW-1:0]       level_next;
    logic                             do_pop;

    assign empty     = (level_reg == '0);
    assign do_pop    = pop && !empty;
    assign head_item = mem_reg[rd_ptr_reg];
    assign level     = level_reg;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        level_next = level_reg + glr_pkg::OUT_LW'(push) - glr_pkg::OUT_LW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/glr_back.sv
// Back end of the glyph cell renderer: cell queue, font store, the 268-slot
// sequencer and a finishing stage that forms each result word.
// Depends on glr_pkg.
module glr_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    input  glr_pkg::op_t                  op,
    output logic                          op_take,
    input  logic [glr_pkg::OUT_LW-1:0]    out_level,
    output logic                          res_push,
    output glr_pkg::response_t            res_item
);

    // Positions inside the window command sequence.
    localparam logic [3:0] WS_COL_CMD   = 4'd0;
    localparam logic [3:0] WS_COL_START = 4'd2;
    localparam logic [3:0] WS_COL_END   = 4'd4;
    localparam logic [3:0] WS_ROW_CMD   = 4'd5;
    localparam logic [3:0] WS_ROW_START = 4'd7;
    localparam logic [3:0] WS_ROW_END   = 4'd9;
    localparam logic [3:0] WS_MEM_WRITE = 4'd10;

    // How the finishing stage forms its byte.
    typedef enum logic [1:0] {
        RK_FIXED,
        RK_HIGH,
        RK_LOW
    } res_kind_t;

    typedef struct packed {
        res_kind_t  kind;
        logic [7:0] fixed_byte;
        logic       dc;
        logic       dropped;
        logic [2:0] bit_sel;
        logic       font_ok;
    } finish_t;

    // Memories and their registered read data.
    glr_pkg::cell_t   cell_mem [glr_pkg::QUEUE_DEPTH];
    logic [7:0]       font_mem [glr_pkg::FONT_DEPTH];
    glr_pkg::cell_t   cell_rd_reg;
    logic [7:0]       font_rd_reg;

    // Queue pointers and sequencer state.
    logic [glr_pkg::QAW-1:0] head_reg;
    logic [glr_pkg::QAW-1:0] head_next;
    logic [glr_pkg::QAW-1:0] tail_reg;
    logic [glr_pkg::QAW-1:0] tail_next;
    logic [glr_pkg::QAW:0]   count_reg;
    logic [glr_pkg::QAW:0]   count_next;
    logic [8:0]              slot_reg;
    logic [8:0]              slot_next;
    logic                    idle_reg;
    logic                    idle_next;
    logic [2:0]              pixel_col_reg;
    logic [2:0]              pixel_col_next;
    logic [3:0]              pixel_row_reg;
    logic [3:0]              pixel_row_next;
    logic                    low_half_reg;
    logic                    low_half_next;
    logic                    latched_reg;
    logic                    latched_next;

    // Finishing stage.
    logic                    s2_valid_reg;
    logic                    s2_valid_next;
    finish_t                 s2_reg;
    finish_t                 s2_next;

    // Memory strobes and lookup terms.
    logic                    cell_wr;
    logic                    cell_rd;
    logic                    font_rd;
    logic                    font_wr;
    logic [6:0]              glyph_off;
    logic                    glyph_ok;
    logic [10:0]             font_rd_addr;
    logic [glr_pkg::OUT_LW:0] occupied;
    logic                    pixel_bit;
    logic [7:0]              win_byte;
    logic                    win_dc;

    // Issue only when the result queue has room for everything in flight.
    assign occupied = {1'b0, out_level} + {{glr_pkg::OUT_LW{1'b0}}, s2_valid_reg};
    assign op_take  = op_valid && (occupied < (glr_pkg::OUT_LW + 1)'(glr_pkg::OUT_DEPTH));

    // Glyph row lookup for the current cell.
    assign glyph_off    = cell_rd_reg.glyph - glr_pkg::GLYPH_BASE;
    assign glyph_ok     = (cell_rd_reg.glyph >= glr_pkg::GLYPH_BASE) &&
                          ({2'b00, glyph_off} < glr_pkg::GLYPH_LIMIT);
    assign font_rd_addr = {glyph_off, pixel_row_reg};

    // Window command and data bytes for the current cell.
    always_comb
    begin
        win_dc   = 1'b1;
        win_byte = 8'h00;
        case (slot_reg[3:0])
            WS_COL_CMD:
            begin
                win_dc   = 1'b0;
                win_byte = glr_pkg::CMD_COL_SET;
            end
            WS_COL_START: win_byte = {1'b0, cell_rd_reg.col, 3'b000};
            WS_COL_END:   win_byte = {1'b0, cell_rd_reg.col, 3'b000} | glr_pkg::COL_SPAN;
            WS_ROW_CMD:
            begin
                win_dc   = 1'b0;
                win_byte = glr_pkg::CMD_ROW_SET;
            end
            WS_ROW_START: win_byte = {cell_rd_reg.row, 4'h0};
            WS_ROW_END:   win_byte = {cell_rd_reg.row, 4'h0} | glr_pkg::ROW_SPAN;
            WS_MEM_WRITE:
            begin
                win_dc   = 1'b0;
                win_byte = glr_pkg::CMD_MEM_WRITE;
            end
            default:
            begin
                win_dc   = 1'b1;
                win_byte = 8'h00;
            end
        endcase
    end

    // Issue stage: carry out one operation and update the sequencer.
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        idle_next      = idle_reg;
        pixel_col_next = pixel_col_reg;
        pixel_row_next = pixel_row_reg;
        low_half_next  = low_half_reg;
        cell_wr        = 1'b0;
        cell_rd        = 1'b0;
        font_wr        = 1'b0;
        font_rd        = 1'b0;
        s2_valid_next  = 1'b0;
        s2_next        = '{kind: RK_FIXED, fixed_byte: win_byte, dc: win_dc,
                           dropped: 1'b0, bit_sel: ~pixel_col_reg, font_ok: glyph_ok};
        if (op_take)
        begin
            unique case (op.kind)
                glr_pkg::OP_TICK:
                begin
                    if (slot_reg == glr_pkg::SLOT_POP)
                    begin
                        // Load the next cell, or go idle when none waits.
                        if (count_reg != '0)
                        begin
                            cell_rd    = 1'b1;
                            head_next  = (head_reg == glr_pkg::QAW'(glr_pkg::QUEUE_DEPTH - 1))
                                         ? '0 : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            idle_next  = 1'b0;
                        end
                        else
                        begin
                            idle_next = 1'b1;
                        end
                    end
                    else if (!idle_reg)
                    begin
                        s2_valid_next = 1'b1;
                        if (slot_reg < glr_pkg::SLOT_WINDOW_END)
                        begin
                            s2_next.kind = RK_FIXED;
                        end
                        else if (!low_half_reg)
                        begin
                            s2_next.kind  = RK_HIGH;
                            s2_next.dc    = 1'b1;
                            font_rd       = glyph_ok;
                            low_half_next = 1'b1;
                        end
                        else
                        begin
                            s2_next.kind   = RK_LOW;
                            s2_next.dc     = 1'b1;
                            low_half_next  = 1'b0;
                            pixel_col_next = pixel_col_reg + 1'b1;
                            if (pixel_col_reg == 3'd7)
                            begin
                                pixel_row_next = pixel_row_reg + 1'b1;
                            end
                        end
                    end
                    slot_next = (slot_reg == glr_pkg::SLOT_POP) ? 9'd0 : slot_reg + 1'b1;
                end
                glr_pkg::OP_ENQUEUE:
                begin
                    if (count_reg == (glr_pkg::QAW + 1)'(glr_pkg::QUEUE_DEPTH))
                    begin
                        // Queue full: refuse the cell and report it.
                        s2_valid_next      = 1'b1;
                        s2_next.kind       = RK_FIXED;
                        s2_next.fixed_byte = 8'h00;
                        s2_next.dc         = 1'b0;
                        s2_next.dropped    = 1'b1;
                    end
                    else
                    begin
                        cell_wr    = 1'b1;
                        tail_next  = (tail_reg == glr_pkg::QAW'(glr_pkg::QUEUE_DEPTH - 1))
                                     ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                glr_pkg::OP_FONT:
                begin
                    font_wr = 1'b1;
                end
                default:
                begin
                    font_wr = 1'b0;
                end
            endcase
        end
    end

    // Memory ports; the cell read register doubles as the current cell.
    always_ff @(posedge clk)
    begin
        if (cell_wr)
        begin
            cell_mem[tail_reg] <= op.cell_data;
        end
        if (cell_rd)
        begin
            cell_rd_reg <= cell_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (font_wr)
        begin
            font_mem[op.font_idx] <= op.font_byte;
        end
        if (font_rd)
        begin
            font_rd_reg <= font_mem[font_rd_addr[glr_pkg::FAW-1:0]];
        end
    end

    // Finishing stage: select pixel colors. A pop can only follow in the
    // issue stage, so the current cell colors are still those of this pixel.
    assign pixel_bit = s2_reg.font_ok & font_rd_reg[s2_reg.bit_sel];

    always_comb
    begin
        latched_next             = latched_reg;
        res_item.dc_level        = s2_reg.dc;
        res_item.enqueue_dropped = s2_reg.dropped;
        res_item.out_byte        = s2_reg.fixed_byte;
        case (s2_reg.kind)
            RK_HIGH:
            begin
                res_item.out_byte = pixel_bit ? cell_rd_reg.fg[15:8] : cell_rd_reg.bg[15:8];
                if (s2_valid_reg)
                begin
                    latched_next = pixel_bit;
                end
            end
            RK_LOW:
            begin
                res_item.out_byte = latched_reg ? cell_rd_reg.fg[7:0] : cell_rd_reg.bg[7:0];
            end
            default:
            begin
                res_item.out_byte = s2_reg.fixed_byte;
            end
        endcase
    end

    assign res_push = s2_valid_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            slot_reg      <= glr_pkg::SLOT_POP;
            idle_reg      <= 1'b1;
            pixel_col_reg <= 3'd0;
            pixel_row_reg <= 4'd0;
            low_half_reg  <= 1'b0;
            latched_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            idle_reg      <= idle_next;
            pixel_col_reg <= pixel_col_next;
            pixel_row_reg <= pixel_row_next;
            low_half_reg  <= low_half_next;
            latched_reg   <= latched_next;
            s2_valid_reg  <= s2_valid_next;
        end
    end

    // Finishing stage payload.
    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

endmodule

### hw/rtl/glyph_cell_spi_renderer.sv
// Top level of the glyph cell renderer: front end, back end and result queue.
// Depends on glr_pkg, glr_front, glr_back and glr_out_fifo.
//
// This block takes one input word per clock cycle (ticks, cell enqueues and
// font byte writes alike) as long as full is low, and delivers at most one
// result word per input word through a queue-style result port. A word that
// produces a result is issued by the back end straight from the front
// operation queue, with a registered font read for high pixel bytes, and then
// passes through the registered finishing stage before it lands in the
// four-word result queue. Sustained rate is one word per cycle, set by the
// single issue slot of the back end and by the room left in the result queue;
// when the consumer stops popping, the back end stops issuing every kind of
// word, words collect in the two-entry front queue, and full rises once it
// holds two. There is no clearing pass after reset: the cell queue and
// the font store hold garbage until written, and a glyph that was never
// loaded draws unspecified pixels.
module glyph_cell_spi_renderer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  glr_pkg::request_t   request,
    output logic                empty,
    input  logic                pop,
    output glr_pkg::response_t  response
);

    logic                          op_valid;
    glr_pkg::op_t                  op;
    logic                          op_take;
    logic [glr_pkg::OUT_LW-1:0]    out_level;
    logic                          res_push;
    glr_pkg::response_t            res_item;

    // Accept and classify input words.
    glr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take)
    );

    // Carry out operations and form result words.
    glr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op        (op),
        .op_take   (op_take),
        .out_level (out_level),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    // Hold result words for the consumer.
    glr_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_item (res_item),
        .pop       (pop),
        .empty     (empty),
        .head_item (response),
        .level     (out_level)
    );

    // The result queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_level <= glr_pkg::OUT_LW'(glr_pkg::OUT_DEPTH))
    else $error("result queue overfilled");

    // A finished word always finds room in the result queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (out_level < glr_pkg::OUT_LW'(glr_pkg::OUT_DEPTH)))
    else $error("result word pushed into a full queue");

    // A waiting operation that is not taken is still waiting next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && !op_take) |=> op_valid)
    else $error("pending operation lost");

    // The empty flag agrees with the queue level.
    assert property (@(posedge clk) disable iff (!rst_n)
        empty == (out_level == '0))
    else $error("empty flag disagrees with queue level");

endmodule

### dv/glyph_cell_checker.sv
// Scoreboard for the glyph cell renderer: watches the input and result word channels,
// predicts every serial link byte and refused enqueue, and compares them in order.
// Depends on glr_pkg for the word types, the sizes and the command codes.
module glyph_cell_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  glr_pkg::request_t   request,
    input  logic                empty,
    input  logic                pop,
    input  glr_pkg::response_t  response,
    output int                  error_count,
    output int                  words_pending
);

    // Predicted renderer state: cell queue, font, sequencer and pixel walk.
    glr_pkg::cell_t cell_fifo [glr_pkg::QUEUE_DEPTH];
    int             cell_head;
    int             cell_count;
    logic [7:0]     font_rom [glr_pkg::FONT_BYTES];
    logic [8:0]     slot;
    logic           idle;
    glr_pkg::cell_t drawn;
    logic [2:0]     pix_col;
    logic [3:0]     pix_row;
    logic           low_next;
    logic           lit;

    // Link bytes and drop flags still owed by the block, oldest first.
    glr_pkg::response_t link_bytes [$];
    int                 mismatch_total;

    // Glyph row lookup; characters outside the font have no set pixels.
    function automatic logic [7:0] glyph_row_bits(logic [6:0] code, logic [3:0] grow);
        int idx;
        idx = int'(code) - int'(glr_pkg::GLYPH_BASE);
        if (idx < 0 || idx >= glr_pkg::FONT_GLYPHS)
            return 8'h00;
        return font_rom[idx * 16 + int'(grow)];
    endfunction

    // One sequencer slot: pop a cell, send a window byte or half a pixel.
    task automatic tick_sequencer();
        glr_pkg::response_t word;
        logic [7:0]         x_pos;
        logic [7:0]         y_pos;
        logic [7:0]         row_bits;
        logic [15:0]        shade;
        word = '0;
        if (slot == glr_pkg::SLOT_POP)
        begin
            if (cell_count != 0)
            begin
                drawn = cell_fifo[cell_head];
                cell_head = (cell_head + 1) % glr_pkg::QUEUE_DEPTH;
                cell_count--;
                idle = 1'b0;
            end
            else
                idle = 1'b1;
        end
        else if (!idle)
        begin
            if (slot < glr_pkg::SLOT_WINDOW_END)
            begin
                x_pos = {1'b0, drawn.col, 3'b000};
                y_pos = {drawn.row, 4'b0000};
                case (slot)
                    9'd0:    word.out_byte = glr_pkg::CMD_COL_SET;
                    9'd2:    word.out_byte = x_pos;
                    9'd4:    word.out_byte = x_pos + glr_pkg::COL_SPAN;
                    9'd5:    word.out_byte = glr_pkg::CMD_ROW_SET;
                    9'd7:    word.out_byte = y_pos;
                    9'd9:    word.out_byte = y_pos + glr_pkg::ROW_SPAN;
                    9'd10:   word.out_byte = glr_pkg::CMD_MEM_WRITE;
                    default: word.out_byte = 8'h00;
                endcase
                // Command bytes go out with the data/command line low.
                word.dc_level = !(slot == 9'd0 || slot == 9'd5 || slot == 9'd10);
            end
            else
            begin
                // The glyph bit is latched on the high byte and reused for the low byte.
                if (!low_next)
                begin
                    row_bits = glyph_row_bits(drawn.glyph, pix_row);
                    lit = row_bits[3'd7 - pix_col];
                end
                shade = lit ? drawn.fg : drawn.bg;
                word.out_byte = low_next ? shade[7:0] : shade[15:8];
                word.dc_level = 1'b1;
                if (low_next)
                begin
                    pix_col = pix_col + 3'd1;
                    if (pix_col == 3'd0)
                        pix_row = pix_row + 4'd1;
                end
                low_next = !low_next;
            end
            link_bytes.push_back(word);
        end
        slot = (slot == glr_pkg::SLOT_POP) ? 9'd0 : slot + 9'd1;
    endtask

    // Apply one accepted input word to the predicted state.
    task automatic take_word(glr_pkg::request_t w);
        glr_pkg::response_t refused;
        case (w.action)
            glr_pkg::ACT_TICK:
                tick_sequencer();
            glr_pkg::ACT_ENQUEUE:
            begin
                if (cell_count >= glr_pkg::QUEUE_DEPTH)
                begin
                    refused = '0;
                    refused.enqueue_dropped = 1'b1;
                    link_bytes.push_back(refused);
                end
                else
                begin
                    cell_fifo[(cell_head + cell_count) % glr_pkg::QUEUE_DEPTH] =
                        '{glyph: w.char_code, col: w.cell_col, row: w.cell_row,
                          fg: w.fg_color, bg: w.back_color};
                    cell_count++;
                end
            end
            glr_pkg::ACT_FONT:
            begin
                // Writes past the end of the font are ignored.
                if (int'(w.font_addr) < glr_pkg::FONT_BYTES)
                    font_rom[w.font_addr] = w.font_byte;
            end
            default:
                ;
        endcase
    endtask

    // Compare one delivered result word with the oldest prediction.
    task automatic check_byte(glr_pkg::response_t got);
        glr_pkg::response_t want;
        if (link_bytes.size() == 0)
        begin
            mismatch_total++;
            if (mismatch_total <= 10)
                $display("ERROR at %0t: unexpected word byte=%02h dc=%0d drop=%0d",
                         $time, got.out_byte, got.dc_level, got.enqueue_dropped);
        end
        else
        begin
            want = link_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.dc_level !== want.dc_level
                || got.enqueue_dropped !== want.enqueue_dropped)
            begin
                mismatch_total++;
                if (mismatch_total <= 10)
                    $display({"ERROR at %0t: expected byte=%02h dc=%0d drop=%0d, ",
                              "got byte=%02h dc=%0d drop=%0d"},
                             $time, want.out_byte, want.dc_level, want.enqueue_dropped,
                             got.out_byte, got.dc_level, got.enqueue_dropped);
            end
        end
    endtask

    // Sample both channels on the rising edge; results are checked before new input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cell_head = 0;
            cell_count = 0;
            slot = glr_pkg::SLOT_POP;
            idle = 1'b1;
            drawn = '0;
            pix_col = 3'd0;
            pix_row = 4'd0;
            low_next = 1'b0;
            lit = 1'b0;
            link_bytes.delete();
            mismatch_total = 0;
        end
        else
        begin
            if (pop && !empty)
                check_byte(response);
            if (push && !full)
                take_word(request);
        end
        error_count <= mismatch_total;
        words_pending <= link_bytes.size();
    end

endmodule

### dv/tb.sv
// Top of the glyph cell renderer testbench: clock, reset, input word stimulus and pop control.
// Depends on glr_pkg, the renderer top level and glyph_cell_checker, which does the checking.
module tb;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 650;
    localparam int PHASE_WORDS  = RANDOM_WORDS / 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 300000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    glr_pkg::request_t  request;
    logic               empty;
    logic               pop;
    glr_pkg::response_t response;

    int        error_count;
    int        words_pending;
    int        sender_idle_pct;
    int        stall_pct;
    logic      hold_go;
    int        cycle_count = 0;
    logic [glr_pkg::FONT_BYTES-1:0] font_written;

    glyph_cell_spi_renderer DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .empty    (empty),
        .pop      (pop),
        .response (response)
    );

    glyph_cell_checker link_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .request       (request),
        .empty         (empty),
        .pop           (pop),
        .response      (response),
        .error_count   (error_count),
        .words_pending (words_pending)
    );

    always #5 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random pops, with one long hold-off so the block backs up.
    initial
    begin : receiver
        logic hold_taken;
        hold_taken = 1'b0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_taken)
            begin
                hold_taken = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // A word with every field random; callers set the action and what matters.
    function automatic glr_pkg::request_t random_word();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(glr_pkg::request_t)-1:0];
    endfunction

    // Offer one word after a random idle gap, then wait until full reads low.
    task automatic offer_word(glr_pkg::request_t w);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        request <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic write_font_byte(int addr, logic [7:0] val);
        glr_pkg::request_t w;
        w = random_word();
        w.action = glr_pkg::ACT_FONT;
        w.font_addr = addr[10:0];
        w.font_byte = val;
        if (addr < glr_pkg::FONT_BYTES)
            font_written[addr] = 1'b1;
        offer_word(w);
    endtask

    task automatic queue_cell(logic [6:0] code, logic [3:0] col, logic [3:0] row,
                              logic [15:0] fg, logic [15:0] bg);
        glr_pkg::request_t w;
        w = random_word();
        w.action = glr_pkg::ACT_ENQUEUE;
        w.char_code = code;
        w.cell_col = col;
        w.cell_row = row;
        w.fg_color = fg;
        w.back_color = bg;
        offer_word(w);
    endtask

    // Stimulus: directed corners, then four random phases with different idling.
    initial
    begin : stimulus
        logic [7:0]        corner_rows [6];
        int                idle_plan [4];
        int                stall_plan [4];
        int                loaded [$];
        glr_pkg::request_t w;
        int                phase;
        int                sent;
        int                pick;
        int                g;
        int                r;
        int                addr;
        logic [6:0]        code;

        corner_rows = '{8'h00, 8'hff, 8'h80, 8'h01, 8'haa, 8'h55};
        idle_plan = '{0, 67, 0, 35};
        stall_plan = '{0, 0, 67, 35};
        rst_n = 1'b0;
        push = 1'b0;
        request = '0;
        hold_go = 1'b0;
        stall_pct = 0;
        sender_idle_pct = 0;
        font_written = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the last glyph of the font with edge patterns in its first six rows.
        for (r = 0; r < 16; r++)
            write_font_byte((glr_pkg::FONT_GLYPHS - 1) * 16 + r,
                            (r < 6) ? corner_rows[r] : 8'($urandom));
        // Writes past the font and the unused action code change nothing.
        write_font_byte(glr_pkg::FONT_BYTES, 8'hff);
        write_font_byte(2047, 8'hff);
        w = '1;
        w.action = ACT_UNUSED;
        offer_word(w);
        // Last glyph in the bottom right corner, then a code below the font.
        queue_cell(7'h7f, 4'hf, 4'hf, 16'hffff, 16'h0000);
        queue_cell(7'h00, 4'h0, 4'h0, 16'h0000, 16'hffff);

        for (phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = idle_plan[phase];
            stall_pct <= stall_plan[phase];
            if (phase == 0)
                hold_go <= 1'b1;
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    w = random_word();
                    w.action = glr_pkg::ACT_TICK;
                    offer_word(w);
                    sent++;
                end
                else if (pick < 88)
                begin
                    // Only fully loaded glyphs or codes below the font are drawn.
                    loaded.delete();
                    for (g = 0; g < glr_pkg::FONT_GLYPHS; g++)
                        if (&font_written[g * 16 +: 16])
                            loaded.push_back(g + int'(glr_pkg::GLYPH_BASE));
                    if (loaded.size() != 0 && $urandom_range(3) != 0)
                        code = 7'(loaded[$urandom_range(loaded.size() - 1)]);
                    else
                        code = 7'($urandom_range(int'(glr_pkg::GLYPH_BASE) - 1));
                    queue_cell(code, 4'($urandom), 4'($urandom),
                               16'($urandom), 16'($urandom));
                    sent++;
                end
                else if (pick < 97)
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        g = $urandom_range(glr_pkg::FONT_GLYPHS - 1);
                        for (r = 0; r < 16; r++)
                            write_font_byte(g * 16 + r, 8'($urandom));
                        sent += 16;
                    end
                    else
                    begin
                        addr = $urandom_range(2047);
                        write_font_byte(addr, 8'($urandom));
                        if (addr < glr_pkg::FONT_BYTES)
                            sent++;
                    end
                end
                else
                begin
                    w = random_word();
                    w.action = ACT_UNUSED;
                    offer_word(w);
                end
            end
            // Pause the sender until every owed word has come out.
            push <= 1'b0;
            @(posedge clk);
            while (words_pending != 0)
                @(posedge clk);
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && words_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
hw/rtl/glr_pkg.sv
hw/rtl/glr_front.sv
hw/rtl/glr_out_fifo.sv
hw/rtl/glr_back.sv
hw/rtl/glyph_cell_spi_renderer.sv
dv/glyph_cell_checker.sv
dv/tb.sv
